[rtl/pwcws_pkg.sv]
// Types and constants shared by the pulse width coded word sender.
`default_nettype none

package pwcws_pkg;

   localparam int unsigned TicksWidth    = 16;
   localparam int unsigned InWordWidth   = 32;
   localparam int unsigned BitsLeftWidth = 6;
   localparam int unsigned RspDataWidth  = 8;

   localparam logic [TicksWidth-1:0] ShortTicksReset = 16'd50;
   localparam logic [TicksWidth-1:0] LongTicksReset  = 16'd100;

   typedef enum logic [0:0] {
      RegShortTicks = 1'b0,
      RegLongTicks  = 1'b1
   } reg_index_type;

   typedef enum logic [4:0] {
      PhIdle    = 5'b00001,
      PhStartHi = 5'b00010,
      PhStartLo = 5'b00100,
      PhBitHi   = 5'b01000,
      PhBitLo   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic start_rejected;
   } result_type;

endpackage

`default_nettype wire

[rtl/pulse_width_coded_word_sender_unit.sv]
// Top level of the pulse width coded word sender: tick-driven serial line encoder.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: word, tuser: kind
//   rsp      out  rsp_tvalid/rsp_tready  tdata: line_level, busy_res; tlast: frame_done;
//                                        tuser: start_rejected
//   csr      in   csr_wr_en              csr_index, csr_wr_data
//
// One beat per cycle while req_tready is high: each req beat updates the frame state
// in the cycle it is accepted and its result is registered.
// A result register plus a one-entry skid stage absorb one beat during an rsp
// stall; req_tready drops only while the skid stage holds a beat.
// Reset clears the frame state, the line, both output stages and the tick
// registers to their defaults; no clearing pass.
`default_nettype none

module pulse_width_coded_word_sender_unit #(
   parameter int unsigned WORD_BITS = 32
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_tvalid,
   output logic                                      req_tready,
   input  wire  [pwcws_pkg::InWordWidth-1:0]         req_tdata,   // [31:0] word
   input  wire  [0:0]                                req_tuser,   // [0] kind
   output logic                                      rsp_tvalid,
   input  wire                                       rsp_tready,
   output logic [pwcws_pkg::RspDataWidth-1:0]        rsp_tdata,   // [0] line_level, [1] busy_res
   output logic                                      rsp_tlast,   // frame_done
   output logic [0:0]                                rsp_tuser,   // [0] start_rejected
   input  wire                                       csr_wr_en,
   input  wire  [0:0]                                csr_index,
   input  wire  [pwcws_pkg::TicksWidth-1:0]          csr_wr_data
);

   localparam logic [pwcws_pkg::BitsLeftWidth-1:0] BitsLast =
      pwcws_pkg::BitsLeftWidth'(WORD_BITS - 1);

   logic [pwcws_pkg::TicksWidth-1:0]    short_ticks_ff;
   logic [pwcws_pkg::TicksWidth-1:0]    long_ticks_ff;

   pwcws_pkg::phase_type                phase_ff, phase_in;
   logic [WORD_BITS-1:0]                shift_ff, shift_in;
   logic [pwcws_pkg::BitsLeftWidth-1:0] bits_left_ff, bits_left_in;
   logic [pwcws_pkg::TicksWidth-1:0]    ticks_ff, ticks_in;
   logic                                line_ff, line_in;

   logic [WORD_BITS-1:0]                load_word;
   logic [pwcws_pkg::TicksWidth-1:0]    short_load, long_load, bit_load;
   logic                                in_frame;
   logic                                start;
   logic                                accept;
   pwcws_pkg::result_type               result;

   pwcws_pkg::result_type               main_ff;
   logic                                main_valid_ff;
   pwcws_pkg::result_type               skid_ff;
   logic                                skid_valid_ff;

   assign start      = req_tuser[0];
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign short_load = (short_ticks_ff == '0) ? '0 : short_ticks_ff - 1'b1;
   assign long_load  = (long_ticks_ff == '0) ? '0 : long_ticks_ff - 1'b1;

   always_comb begin
      load_word = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (i < pwcws_pkg::InWordWidth) begin
            load_word[i] = req_tdata[i];
         end
      end
   end

   always_comb begin
      in_frame = (phase_ff == pwcws_pkg::PhStartHi) || (phase_ff == pwcws_pkg::PhStartLo) ||
                 (phase_ff == pwcws_pkg::PhBitHi)   || (phase_ff == pwcws_pkg::PhBitLo);
   end

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      ticks_in     = ticks_ff;
      line_in      = line_ff;
      bit_load     = long_load;
      result       = '0;
      if (!in_frame) begin
         phase_in = pwcws_pkg::PhIdle;
         ticks_in = '0;
         line_in  = 1'b0;
         if (start) begin
            shift_in     = load_word;
            bits_left_in = '0;
            phase_in     = pwcws_pkg::PhStartHi;
            line_in      = 1'b1;
            ticks_in     = short_load;
         end
      end else begin
         result.start_rejected = start;
         if (ticks_ff != '0) begin
            ticks_in = ticks_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               pwcws_pkg::PhStartHi: begin
                  phase_in = pwcws_pkg::PhStartLo;
                  line_in  = 1'b0;
                  ticks_in = short_load;
               end
               pwcws_pkg::PhStartLo: begin
                  bits_left_in = BitsLast;
                  bit_load     = shift_ff[0] ? short_load : long_load;
                  phase_in     = pwcws_pkg::PhBitHi;
                  line_in      = 1'b1;
                  ticks_in     = bit_load;
               end
               pwcws_pkg::PhBitHi: begin
                  phase_in = pwcws_pkg::PhBitLo;
                  line_in  = 1'b0;
                  ticks_in = long_load;
               end
               default: begin
                  if (bits_left_ff != '0) begin
                     bits_left_in = bits_left_ff - 1'b1;
                     shift_in     = shift_ff >> 1;
                     bit_load     = shift_in[0] ? short_load : long_load;
                     phase_in     = pwcws_pkg::PhBitHi;
                     line_in      = 1'b1;
                     ticks_in     = bit_load;
                  end
               end
            endcase
         end
         if ((phase_in == pwcws_pkg::PhBitLo) && (bits_left_in == '0) && (ticks_in == '0)) begin
            result.frame_done = 1'b1;
            phase_in          = pwcws_pkg::PhIdle;
            line_in           = 1'b0;
            shift_in          = '0;
         end
      end
      result.line_level = line_in;
      result.busy_res   = (phase_in != pwcws_pkg::PhIdle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff <= pwcws_pkg::ShortTicksReset;
         long_ticks_ff  <= pwcws_pkg::LongTicksReset;
      end else if (csr_wr_en) begin
         unique case (pwcws_pkg::reg_index_type'(csr_index))
            pwcws_pkg::RegShortTicks: short_ticks_ff <= csr_wr_data;
            pwcws_pkg::RegLongTicks:  long_ticks_ff  <= csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pwcws_pkg::PhIdle;
         shift_ff     <= '0;
         bits_left_ff <= '0;
         ticks_ff     <= '0;
         line_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         bits_left_ff <= bits_left_in;
         ticks_ff     <= ticks_in;
         line_ff      <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || rsp_tready) begin
         main_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {{(pwcws_pkg::RspDataWidth-2){1'b0}}, main_ff.busy_res,
                        main_ff.line_level};
   assign rsp_tlast  = main_ff.frame_done;
   assign rsp_tuser  = main_ff.start_rejected;

endmodule

`default_nettype wire

[sim/pwcws_line_checker.sv]
// Checker for the pulse width coded word sender: predicts each line result and compares it.
module pwcws_line_checker
   import pwcws_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   input  wire                          req_tready,
   input  wire  [InWordWidth-1:0]       req_tdata,    // [31:0] word
   input  wire  [0:0]                   req_tuser,    // [0] kind
   input  wire                          rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire  [RspDataWidth-1:0]      rsp_tdata,    // [0] line_level, [1] busy_res
   input  wire                          rsp_tlast,    // frame_done
   input  wire  [0:0]                   rsp_tuser,    // [0] start_rejected
   input  wire                          csr_wr_en,
   input  wire  [0:0]                   csr_index,
   input  wire  [TicksWidth-1:0]        csr_wr_data,
   output int                           fail_count,
   output int                           open_count,
   output logic                         frame_busy
);

   logic [TicksWidth-1:0]    short_len;
   logic [TicksWidth-1:0]    long_len;
   phase_type                cur_phase;
   logic [InWordWidth-1:0]   shift_bits;
   logic [BitsLeftWidth-1:0] bits_remaining;
   logic [TicksWidth-1:0]    ticks_remaining;
   logic                     line_q;
   result_type               line_due[$];
   result_type               seen;
   result_type               want;

   function automatic void enter_step(input phase_type p, input logic lvl,
                                      input logic [TicksWidth-1:0] dur);
      cur_phase       = p;
      line_q          = lvl;
      ticks_remaining = ((dur == '0) ? TicksWidth'(1) : dur) - TicksWidth'(1);
   endfunction

   function automatic result_type next_line_state(input logic start,
                                                  input logic [InWordWidth-1:0] word);
      result_type r;
      r = '0;
      if (cur_phase == PhIdle) begin
         ticks_remaining = '0;
         line_q          = 1'b0;
         if (start) begin
            shift_bits     = word;
            bits_remaining = '0;
            enter_step(PhStartHi, 1'b1, short_len);
         end
      end else begin
         if (start) r.start_rejected = 1'b1;
         if (ticks_remaining != '0) begin
            ticks_remaining = ticks_remaining - TicksWidth'(1);
         end else begin
            case (cur_phase)
               PhStartHi: enter_step(PhStartLo, 1'b0, short_len);
               PhStartLo: begin
                  bits_remaining = BitsLeftWidth'(InWordWidth - 1);
                  enter_step(PhBitHi, 1'b1, shift_bits[0] ? short_len : long_len);
               end
               PhBitHi: enter_step(PhBitLo, 1'b0, long_len);
               default: begin
                  if (bits_remaining != '0) begin
                     bits_remaining = bits_remaining - BitsLeftWidth'(1);
                     shift_bits     = shift_bits >> 1;
                     enter_step(PhBitHi, 1'b1, shift_bits[0] ? short_len : long_len);
                  end
               end
            endcase
         end
         if (cur_phase == PhBitLo && bits_remaining == '0 && ticks_remaining == '0) begin
            r.frame_done = 1'b1;
            cur_phase    = PhIdle;
            line_q       = 1'b0;
            shift_bits   = '0;
         end
      end
      r.line_level = line_q;
      r.busy_res   = (cur_phase != PhIdle);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         short_len       = ShortTicksReset;
         long_len        = LongTicksReset;
         cur_phase       = PhIdle;
         shift_bits      = '0;
         bits_remaining  = '0;
         ticks_remaining = '0;
         line_q          = 1'b0;
         line_due.delete();
         open_count <= 0;
         frame_busy <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.line_level     = rsp_tdata[0];
            seen.busy_res       = rsp_tdata[1];
            seen.frame_done     = rsp_tlast;
            seen.start_rejected = rsp_tuser[0];
            if (line_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected rsp beat: line %0b busy %0b done %0b rejected %0b",
                           seen.line_level, seen.busy_res, seen.frame_done,
                           seen.start_rejected);
               fail_count++;
            end else begin
               want = line_due.pop_front();
               if (seen.line_level != want.line_level || seen.busy_res != want.busy_res ||
                   seen.frame_done != want.frame_done ||
                   seen.start_rejected != want.start_rejected) begin
                  if (fail_count < 10)
                     $display({"rsp mismatch: expected line %0b busy %0b done %0b ",
                               "rejected %0b, got line %0b busy %0b done %0b rejected %0b"},
                              want.line_level, want.busy_res, want.frame_done,
                              want.start_rejected, seen.line_level, seen.busy_res,
                              seen.frame_done, seen.start_rejected);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            line_due.push_back(next_line_state(req_tuser[0], req_tdata));
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               RegShortTicks: short_len = csr_wr_data;
               RegLongTicks:  long_len  = csr_wr_data;
               default: ;
            endcase
         end
         open_count <= line_due.size();
         frame_busy <= (cur_phase != PhIdle);
      end
   end

endmodule

[sim/pulse_width_coded_word_sender_unit_test.sv]
// Testbench top for the pulse width coded word sender: stimulus, flow control and verdict.
module pulse_width_coded_word_sender_unit_test;
   import pwcws_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [InWordWidth-1:0]   req_tdata;    // [31:0] word
   logic [0:0]               req_tuser;    // [0] kind
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;    // [0] line_level, [1] busy_res
   logic                     rsp_tlast;    // frame_done
   logic [0:0]               rsp_tuser;    // [0] start_rejected
   logic                     csr_wr_en;
   reg_index_type            csr_index;
   logic [TicksWidth-1:0]    csr_wr_data;
   int                       fail_count;
   int                       open_count;
   logic                     frame_busy;
   bit                       hold_rsp = 1'b0;
   bit                       calm = 1'b0;

   pulse_width_coded_word_sender_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pwcws_line_checker line_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .open_count  (open_count),
      .frame_busy  (frame_busy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 5_000_000);
      $display("status: fail");
      $finish;
   end

   initial begin
      int quiet;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 15) < 2) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            rsp_tready <= 1'b1;
            quiet = $urandom_range(20, 60);
            while (quiet > 0 && !hold_rsp) begin
               @(posedge clock);
               quiet--;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic offer_beat(input logic kind, input logic [InWordWidth-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_req(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drop valid, then wait for all results and optionally for the frame to end
   task automatic wait_quiet(input bit frame_too);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0 || (frame_too && frame_busy));
   endtask

   // tick until the frame ends; all_starts lands a start on the finishing beat
   task automatic tick_until_idle(input bit all_starts);
      if (all_starts) begin
         do begin
            offer_beat(1'b1, $urandom);
            req_tvalid <= 1'b0;
            @(posedge clock);
         end while (frame_busy);
      end else begin
         do offer_beat(1'b0, $urandom); while (frame_busy);
      end
   endtask

   task automatic load_tick_lengths(input logic [TicksWidth-1:0] short_val,
                                    input logic [TicksWidth-1:0] long_val);
      csr_wr_en   <= 1'b1;
      csr_index   <= RegShortTicks;
      csr_wr_data <= short_val;
      @(posedge clock);
      csr_index   <= RegLongTicks;
      csr_wr_data <= long_val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [TicksWidth-1:0] short_set[3];
      logic [TicksWidth-1:0] long_set[3];
      bit gappy;
      short_set   = '{16'd0, 16'd2, 16'd1};
      long_set    = '{16'd1, 16'd1, 16'd2};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= RegShortTicks;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      offer_beat(1'b0, '1);
      offer_beat(1'b0, '0);
      wait_quiet(1'b1);

      load_tick_lengths(16'd0, 16'd0);
      offer_beat(1'b1, 32'hFFFF_FFFF);
      offer_beat(1'b1, 32'h0000_0000);
      tick_until_idle(1'b1);
      wait_quiet(1'b1);

      load_tick_lengths(16'd1, 16'd1);
      hold_rsp = 1'b1;
      offer_beat(1'b1, 32'hA5A5_5A5A);
      repeat (40) offer_beat(1'b0, $urandom);
      tick_until_idle(1'b0);
      wait_quiet(1'b1);

      load_tick_lengths(16'd2, 16'hFFFF);
      repeat (3) offer_beat(1'b0, $urandom);
      wait_quiet(1'b1);

      for (int p = 0; p < 3; p++) begin
         if (p == 2) calm = 1'b1;
         load_tick_lengths(short_set[p], long_set[p]);
         gappy = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 40; i++) begin
            if (p == 1 && i == 20) wait_quiet(1'b0);
            if (gappy && !calm && $urandom_range(0, 5) == 0)
               pause_req($urandom_range(1, 9));
            offer_beat($urandom_range(0, 11) == 0, $urandom);
         end
         tick_until_idle(1'b0);
         wait_quiet(1'b1);
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && open_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
